### rtl/core/kdds_pkg.sv
// Shared types and constants of the keypad DDS waveform generator.
package kdds_pkg;

  typedef enum logic [1:0] {
    WAVE_SQUARE = 2'd0,
    WAVE_SINE   = 2'd1,
    WAVE_TRI    = 2'd2,
    WAVE_SAW    = 2'd3
  } wave_t;

  typedef struct packed {
    wave_t wave;
    logic  sq_hi;
  } tick_ctl_t;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned FULL_W     = 12;
  localparam int unsigned PEAK_W     = 11;
  localparam int unsigned OFFS_W     = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned KEY_W      = 4;
  localparam int unsigned FREQ_W     = 3;
  localparam int unsigned DUTY_W     = 4;
  localparam int unsigned DUTY_DIV   = 10;
  localparam int unsigned JQ_DEPTH   = 4;
  localparam int unsigned OQ_DEPTH   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINE_PEAK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINE_OFFSET = 2'd2;

  localparam logic [FULL_W-1:0] FULL_SCALE_RST  = 12'd4095;
  localparam logic [PEAK_W-1:0] SINE_PEAK_RST   = 11'd2047;
  localparam logic [OFFS_W-1:0] SINE_OFFSET_RST = 12'd2048;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  localparam logic [KEY_W-1:0] KEY_DUTY_RST = 4'd0;
  localparam logic [KEY_W-1:0] KEY_FREQ_LO  = 4'd1;
  localparam logic [KEY_W-1:0] KEY_FREQ_HI  = 4'd5;
  localparam logic [KEY_W-1:0] KEY_SINE     = 4'd6;
  localparam logic [KEY_W-1:0] KEY_TRI      = 4'd7;
  localparam logic [KEY_W-1:0] KEY_SAW      = 4'd8;
  localparam logic [KEY_W-1:0] KEY_SQUARE   = 4'd9;
  localparam logic [KEY_W-1:0] KEY_DUTY_DN  = 4'd10;
  localparam logic [KEY_W-1:0] KEY_DUTY_UP  = 4'd11;

  localparam logic [FREQ_W-1:0] FREQ_RST     = 3'd1;
  localparam logic [DUTY_W-1:0] DUTY_DEFAULT = 4'd4;

  // Q1.15 polynomial sine coefficients
  localparam logic [11:0] SIN_C1   = 12'd2320;
  localparam logic [14:0] SIN_C2   = 15'd21024;
  localparam logic [15:0] SIN_C3   = 16'd51472;
  localparam logic [15:0] Q15_ONE  = 16'd32768;
  localparam logic [14:0] Q15_MAX  = 15'd32767;

endpackage

### rtl/core/kdds_fifo.sv
// Small register-based FIFO used for the job queue and the result queue.
module kdds_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  always_comb begin
    full     = (cnt_r == CW'(DEPTH));
    empty    = (cnt_r == '0);
    count    = cnt_r;
    rdata    = mem_r[rptr_r];
    do_push  = push && !full;
    do_pop   = pop && !empty;
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

### rtl/core/kdds_front.sv
// Front end: key decode, generator state and phase accumulator, tick job issue.
module kdds_front #(
  parameter int unsigned TABLE_SIZE = 256,
  parameter int unsigned DUTY_STEPS = 9,
  localparam int unsigned IDX_W = $clog2(TABLE_SIZE)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             item_vld,
  input  logic                             operation,
  input  logic [kdds_pkg::KEY_W-1:0]       key,
  output logic                             job_push,
  output kdds_pkg::tick_ctl_t              job_ctl,
  output logic [IDX_W-1:0]                 job_idx
);

  localparam int unsigned TW = IDX_W + 1;

  // square high while index <= ((duty+1)*N)/10
  localparam logic [TW-1:0] DUTY_THR [16] = '{
    TW'((1 * TABLE_SIZE) / kdds_pkg::DUTY_DIV),
    TW'((2 * TABLE_SIZE) / kdds_pkg::DUTY_DIV),
    TW'((3 * TABLE_SIZE) / kdds_pkg::DUTY_DIV),
    TW'((4 * TABLE_SIZE) / kdds_pkg::DUTY_DIV),
    TW'((5 * TABLE_SIZE) / kdds_pkg::DUTY_DIV),
    TW'((6 * TABLE_SIZE) / kdds_pkg::DUTY_DIV),
    TW'((7 * TABLE_SIZE) / kdds_pkg::DUTY_DIV),
    TW'((8 * TABLE_SIZE) / kdds_pkg::DUTY_DIV),
    TW'((9 * TABLE_SIZE) / kdds_pkg::DUTY_DIV),
    TW'((10 * TABLE_SIZE) / kdds_pkg::DUTY_DIV),
    TW'(TABLE_SIZE), TW'(TABLE_SIZE), TW'(TABLE_SIZE),
    TW'(TABLE_SIZE), TW'(TABLE_SIZE), TW'(TABLE_SIZE)
  };

  kdds_pkg::wave_t                  wave_r, wave_nxt;
  logic [kdds_pkg::FREQ_W-1:0]      freq_r, freq_nxt;
  logic [kdds_pkg::DUTY_W-1:0]      duty_r, duty_nxt;
  logic [IDX_W-1:0]                 idx_r, idx_nxt;
  logic [TW-1:0]                    step_sum;
  logic                             is_sq;

  always_comb begin
    wave_nxt      = wave_r;
    freq_nxt      = freq_r;
    duty_nxt      = duty_r;
    idx_nxt       = idx_r;
    job_push      = 1'b0;
    is_sq         = (wave_r == kdds_pkg::WAVE_SQUARE);
    step_sum      = {1'b0, idx_r} + TW'(freq_r);
    job_ctl.wave  = wave_r;
    job_ctl.sq_hi = ({1'b0, idx_r} <= DUTY_THR[duty_r]);
    job_idx       = idx_r;
    if (item_vld) begin
      if (operation == kdds_pkg::OP_TICK) begin
        job_push = 1'b1;
        idx_nxt  = (step_sum >= TW'(TABLE_SIZE)) ? '0 : step_sum[IDX_W-1:0];
      end else if (key == kdds_pkg::KEY_DUTY_RST) begin
        if (is_sq) begin
          duty_nxt = kdds_pkg::DUTY_DEFAULT;
        end
      end else if (key >= kdds_pkg::KEY_FREQ_LO && key <= kdds_pkg::KEY_FREQ_HI) begin
        freq_nxt = key[kdds_pkg::FREQ_W-1:0];
      end else if (key == kdds_pkg::KEY_SINE) begin
        wave_nxt = kdds_pkg::WAVE_SINE;
      end else if (key == kdds_pkg::KEY_TRI) begin
        wave_nxt = kdds_pkg::WAVE_TRI;
      end else if (key == kdds_pkg::KEY_SAW) begin
        wave_nxt = kdds_pkg::WAVE_SAW;
      end else if (key == kdds_pkg::KEY_SQUARE) begin
        wave_nxt = kdds_pkg::WAVE_SQUARE;
      end else if (key == kdds_pkg::KEY_DUTY_DN) begin
        if (is_sq && duty_r != '0) begin
          duty_nxt = duty_r - 4'd1;
        end
      end else if (key == kdds_pkg::KEY_DUTY_UP) begin
        if (is_sq && ({1'b0, duty_r} + 5'd1 < 5'(DUTY_STEPS))) begin
          duty_nxt = duty_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= kdds_pkg::WAVE_SQUARE;
      freq_r <= kdds_pkg::FREQ_RST;
      duty_r <= kdds_pkg::DUTY_DEFAULT;
      idx_r  <= '0;
    end else begin
      wave_r <= wave_nxt;
      freq_r <= freq_nxt;
      duty_r <= duty_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

### rtl/core/kdds_back.sv
// Back end: seven-stage sample pipeline (ramp divide, polynomial sine, scaling).
module kdds_back #(
  parameter int unsigned TABLE_SIZE  = 256,
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned OUT_DEPTH   = 16,
  localparam int unsigned IDX_W = $clog2(TABLE_SIZE),
  localparam int unsigned CW    = $clog2(OUT_DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [kdds_pkg::FULL_W-1:0]        full_scale,
  input  logic [kdds_pkg::PEAK_W-1:0]        sine_peak,
  input  logic [kdds_pkg::OFFS_W-1:0]        sine_offset,
  input  logic                               job_empty,
  input  kdds_pkg::tick_ctl_t                job_ctl,
  input  logic [IDX_W-1:0]                   job_idx,
  output logic                               job_pop,
  input  logic [CW-1:0]                      oq_cnt,
  output logic                               res_vld,
  output logic [kdds_pkg::SAMPLE_W-1:0]      res_sample
);

  localparam int unsigned STAGES = 7;
  localparam int unsigned FW     = kdds_pkg::FULL_W;
  localparam int unsigned HALF   = TABLE_SIZE / 2;
  localparam int unsigned LN     = $clog2(TABLE_SIZE);
  localparam int unsigned LH     = $clog2(HALF);

  // ramp: floor(F*i/D) via exact reciprocal multiply
  localparam int unsigned RP_W = FW + IDX_W;
  localparam int unsigned RM_W = RP_W + 1;
  localparam int unsigned RQ_W = RP_W + RM_W;
  localparam logic [63:0] RM_N_64 =
    ((64'd1 << (RP_W + LN)) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [63:0] RM_H_64 =
    ((64'd1 << (RP_W + LH)) + 64'(HALF) - 64'd1) / 64'(HALF);
  localparam logic [RM_W-1:0] RM_N = RM_N_64[RM_W-1:0];
  localparam logic [RM_W-1:0] RM_H = RM_H_64[RM_W-1:0];
  localparam int unsigned SH_N = RP_W + LN;
  localparam int unsigned SH_H = RP_W + LH;

  // sine phase: floor(i*2^17/N)
  localparam int unsigned PS   = IDX_W + 17;
  localparam int unsigned SM_W = PS + 1;
  localparam int unsigned PM_W = IDX_W + SM_W;
  localparam logic [63:0] SM_64 =
    ((64'd1 << (PS + LN)) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [SM_W-1:0] SM = SM_64[SM_W-1:0];
  localparam int unsigned SSH = PS + LN - 17;

  localparam logic [16:0] SAT_MAX = 17'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [STAGES-1:0] vld_r, vld_nxt;
  logic [CW-1:0]     inflight;
  logic              issue;

  // stage 1
  kdds_pkg::wave_t   s1_wave_r;
  logic              s1_sqhi_r, s1_upper_r;
  logic [PM_W-1:0]   s1_pm_r;
  logic [RP_W-1:0]   s1_rp_r;
  logic              s1_upper;
  logic [IDX_W-1:0]  s1_opnd;
  // stage 2
  kdds_pkg::wave_t   s2_wave_r;
  logic              s2_sqhi_r, s2_upper_r, s2_neg_r;
  logic [15:0]       s2_xm_r, s2_x2_r;
  logic [FW-1:0]     s2_rq_r;
  logic [PM_W-1:0]   s2_u_sh;
  logic [16:0]       s2_u;
  logic [15:0]       s2_xm;
  logic [31:0]       s2_xx;
  logic [RQ_W-1:0]   s2_rprod, s2_rsh;
  // stage 3
  kdds_pkg::wave_t   s3_wave_r;
  logic              s3_sqhi_r, s3_neg_r;
  logic [15:0]       s3_xm_r, s3_x2_r;
  logic [11:0]       s3_t1_r;
  logic [FW-1:0]     s3_rv_r;
  logic [27:0]       s3_t1p;
  // stage 4
  kdds_pkg::wave_t   s4_wave_r;
  logic              s4_sqhi_r, s4_neg_r;
  logic [15:0]       s4_xm_r;
  logic [14:0]       s4_t2_r;
  logic [FW-1:0]     s4_rv_r;
  logic [14:0]       s4_a;
  logic [30:0]       s4_t2p;
  // stage 5
  kdds_pkg::wave_t   s5_wave_r;
  logic              s5_sqhi_r, s5_neg_r;
  logic [14:0]       s5_y_r;
  logic [FW-1:0]     s5_rv_r;
  logic [15:0]       s5_b;
  logic [31:0]       s5_yp;
  // stage 6
  kdds_pkg::wave_t   s6_wave_r;
  logic              s6_sqhi_r, s6_neg_r;
  logic [25:0]       s6_sp_r;
  logic [FW-1:0]     s6_rv_r;
  // stage 7
  logic [kdds_pkg::SAMPLE_W-1:0] s7_sample_r;
  logic [26:0]       s7_off;
  logic [27:0]       s7_sum;
  logic [26:0]       s7_diff;
  logic [12:0]       s7_sine, s7_val;

  always_comb begin
    inflight = CW'($countones(vld_r));
    issue    = !job_empty &&
               (({1'b0, inflight} + {1'b0, oq_cnt}) < (CW + 1)'(OUT_DEPTH));
    job_pop  = issue;
    vld_nxt  = {vld_r[STAGES-2:0], issue};
    res_vld  = vld_r[STAGES-1];
    res_sample = s7_sample_r;

    s1_upper = (job_idx >= IDX_W'(HALF));
    if (job_ctl.wave == kdds_pkg::WAVE_SAW || !s1_upper) begin
      s1_opnd = job_idx;
    end else begin
      s1_opnd = job_idx - IDX_W'(HALF);
    end

    s2_u_sh  = s1_pm_r >> SSH;
    s2_u     = s2_u_sh[16:0];
    s2_xm    = s2_u[15] ? kdds_pkg::Q15_ONE - {1'b0, s2_u[14:0]} : {1'b0, s2_u[14:0]};
    s2_xx    = 32'(s2_xm) * 32'(s2_xm);
    s2_rprod = RQ_W'(s1_rp_r) * RQ_W'((s1_wave_r == kdds_pkg::WAVE_SAW) ? RM_N : RM_H);
    s2_rsh   = (s1_wave_r == kdds_pkg::WAVE_SAW) ? (s2_rprod >> SH_N) : (s2_rprod >> SH_H);

    s3_t1p = 28'(s2_x2_r) * 28'(kdds_pkg::SIN_C1);

    s4_a   = kdds_pkg::SIN_C2 - 15'(s3_t1_r);
    s4_t2p = 31'(s4_a) * 31'(s3_x2_r);

    s5_b  = kdds_pkg::SIN_C3 - 16'(s4_t2_r);
    s5_yp = 32'(s5_b) * 32'(s4_xm_r);

    s7_off  = {sine_offset, 15'd0};
    s7_sum  = 28'(s7_off) + 28'(s6_sp_r);
    s7_diff = s7_off - 27'(s6_sp_r);
    if (!s6_neg_r) begin
      s7_sine = s7_sum[27:15];
    end else if (s7_off >= 27'(s6_sp_r)) begin
      s7_sine = {1'b0, s7_diff[26:15]};
    end else begin
      s7_sine = '0;
    end
    case (s6_wave_r)
      kdds_pkg::WAVE_SQUARE: s7_val = s6_sqhi_r ? {1'b0, full_scale} : '0;
      kdds_pkg::WAVE_SINE:   s7_val = s7_sine;
      default:               s7_val = {1'b0, s6_rv_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_wave_r  <= job_ctl.wave;
    s1_sqhi_r  <= job_ctl.sq_hi;
    s1_upper_r <= s1_upper;
    s1_pm_r    <= PM_W'(job_idx) * PM_W'(SM);
    s1_rp_r    <= RP_W'(full_scale) * RP_W'(s1_opnd);

    s2_wave_r  <= s1_wave_r;
    s2_sqhi_r  <= s1_sqhi_r;
    s2_upper_r <= s1_upper_r;
    s2_neg_r   <= s2_u[16];
    s2_xm_r    <= s2_xm;
    s2_x2_r    <= s2_xx[30:15];
    s2_rq_r    <= s2_rsh[FW-1:0];

    s3_wave_r  <= s2_wave_r;
    s3_sqhi_r  <= s2_sqhi_r;
    s3_neg_r   <= s2_neg_r;
    s3_xm_r    <= s2_xm_r;
    s3_x2_r    <= s2_x2_r;
    s3_t1_r    <= s3_t1p[26:15];
    s3_rv_r    <= (s2_wave_r == kdds_pkg::WAVE_TRI && s2_upper_r) ?
                  full_scale - s2_rq_r : s2_rq_r;

    s4_wave_r  <= s3_wave_r;
    s4_sqhi_r  <= s3_sqhi_r;
    s4_neg_r   <= s3_neg_r;
    s4_xm_r    <= s3_xm_r;
    s4_t2_r    <= s4_t2p[29:15];
    s4_rv_r    <= s3_rv_r;

    s5_wave_r  <= s4_wave_r;
    s5_sqhi_r  <= s4_sqhi_r;
    s5_neg_r   <= s4_neg_r;
    s5_y_r     <= (s5_yp[31:15] > 17'(kdds_pkg::Q15_MAX)) ? kdds_pkg::Q15_MAX :
                  s5_yp[29:15];
    s5_rv_r    <= s4_rv_r;

    s6_wave_r  <= s5_wave_r;
    s6_sqhi_r  <= s5_sqhi_r;
    s6_neg_r   <= s5_neg_r;
    s6_sp_r    <= 26'(sine_peak) * 26'(s5_y_r);
    s6_rv_r    <= s5_rv_r;

    s7_sample_r <= (17'(s7_val) > SAT_MAX) ? SAT_MAX[kdds_pkg::SAMPLE_W-1:0] :
                   s7_val[kdds_pkg::SAMPLE_W-1:0];
  end

endmodule

### rtl/core/keypad_dds_waveform_generator_top.sv
// Top level of the keypad DDS waveform generator: config registers, queues, front and back.
//
//  channel  | ports                          | transaction when
//  ---------+--------------------------------+---------------------------
//  input    | in_push/in_full, in_operation, | in_push && !in_full
//           | in_key                         |
//  result   | out_empty/out_pop, out_sample  | out_pop && !out_empty
//  config   | cfg_we, cfg_idx, cfg_data      | cfg_we
//
// One input transaction per cycle while !in_full; a tick yields a sample, a key press none.
// The back end is a 7-stage pipeline; it issues only while the 16-entry result queue
// has room for everything in flight, so a stalled consumer backs up into the 4-entry
// job queue and then raises in_full.
// Reset (rst_n low, synchronous) empties both queues and restores registers and state.
module keypad_dds_waveform_generator_top #(
  parameter int unsigned TABLE_SIZE  = 256,
  parameter int unsigned DUTY_STEPS  = 9,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [kdds_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [kdds_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_operation,
  input  logic [kdds_pkg::KEY_W-1:0]           in_key,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [kdds_pkg::SAMPLE_W-1:0]        out_sample
);

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
  localparam int unsigned CTL_W = $bits(kdds_pkg::tick_ctl_t);
  localparam int unsigned JW    = CTL_W + IDX_W;
  localparam int unsigned OCW   = $clog2(kdds_pkg::OQ_DEPTH + 1);
  localparam int unsigned JCW   = $clog2(kdds_pkg::JQ_DEPTH + 1);

  logic [kdds_pkg::FULL_W-1:0] full_scale_r;
  logic [kdds_pkg::PEAK_W-1:0] sine_peak_r;
  logic [kdds_pkg::OFFS_W-1:0] sine_offset_r;

  logic                    in_acc;
  logic                    job_push;
  kdds_pkg::tick_ctl_t     job_ctl;
  logic [IDX_W-1:0]        job_idx;
  logic [JW-1:0]           jq_rdata;
  logic                    jq_empty, jq_pop;
  logic [JCW-1:0]          jq_cnt;
  kdds_pkg::tick_ctl_t     jq_ctl;
  logic [IDX_W-1:0]        jq_idx;
  logic                    res_vld;
  logic [kdds_pkg::SAMPLE_W-1:0] res_sample;
  logic                    oq_full;
  logic [OCW-1:0]          oq_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r  <= kdds_pkg::FULL_SCALE_RST;
      sine_peak_r   <= kdds_pkg::SINE_PEAK_RST;
      sine_offset_r <= kdds_pkg::SINE_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        kdds_pkg::CFG_FULL_SCALE:  full_scale_r  <= cfg_data[kdds_pkg::FULL_W-1:0];
        kdds_pkg::CFG_SINE_PEAK:   sine_peak_r   <= cfg_data[kdds_pkg::PEAK_W-1:0];
        kdds_pkg::CFG_SINE_OFFSET: sine_offset_r <= cfg_data[kdds_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc = in_push && !in_full;
  assign jq_ctl = kdds_pkg::tick_ctl_t'(jq_rdata[JW-1:IDX_W]);
  assign jq_idx = jq_rdata[IDX_W-1:0];

  kdds_front #(
    .TABLE_SIZE (TABLE_SIZE),
    .DUTY_STEPS (DUTY_STEPS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (in_acc),
    .operation (in_operation),
    .key       (in_key),
    .job_push  (job_push),
    .job_ctl   (job_ctl),
    .job_idx   (job_idx)
  );

  kdds_fifo #(
    .WIDTH (JW),
    .DEPTH (kdds_pkg::JQ_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata ({job_ctl, job_idx}),
    .pop   (jq_pop),
    .rdata (jq_rdata),
    .full  (in_full),
    .empty (jq_empty),
    .count (jq_cnt)
  );

  kdds_back #(
    .TABLE_SIZE  (TABLE_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS),
    .OUT_DEPTH   (kdds_pkg::OQ_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .full_scale  (full_scale_r),
    .sine_peak   (sine_peak_r),
    .sine_offset (sine_offset_r),
    .job_empty   (jq_empty),
    .job_ctl     (jq_ctl),
    .job_idx     (jq_idx),
    .job_pop     (jq_pop),
    .oq_cnt      (oq_cnt),
    .res_vld     (res_vld),
    .res_sample  (res_sample)
  );

  kdds_fifo #(
    .WIDTH (kdds_pkg::SAMPLE_W),
    .DEPTH (kdds_pkg::OQ_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_vld),
    .wdata (res_sample),
    .pop   (out_pop),
    .rdata (out_sample),
    .full  (oq_full),
    .empty (out_empty),
    .count (oq_cnt)
  );

  a_no_oq_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> !oq_full)
    else $error("result pushed into full result queue");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    jq_pop |-> !jq_empty)
    else $error("back end issued from empty job queue");

  a_key_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation == kdds_pkg::OP_KEY) |-> !job_push)
    else $error("key press produced a sample job");

  a_jq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    jq_cnt <= JCW'(kdds_pkg::JQ_DEPTH))
    else $error("job queue count out of range");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule
